@@ hw/rtl/cgd_pkg.sv @@
`timescale 1ns / 1ps
// Package with shared constants and types for the grid deposition block.
package cgd_pkg;
	localparam int GRID_MAX_DEF  = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ACC_WIDTH_DEF = 48;
	localparam int OUT_W         = 48;
	localparam int IDX_W         = 16;
	localparam int CFG_IDX_W     = 3;

	localparam logic [1:0] REQ_DEPOSIT = 2'd0;
	localparam logic [1:0] REQ_READ    = 2'd1;
	localparam logic [1:0] REQ_RDCLR   = 2'd2;
	localparam logic [1:0] REQ_INVALID = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIMS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PADDING   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MASS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ITEM_MASS = 3'd4;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCALE,
		ST_SPLIT,
		ST_WRAP,
		ST_CORNER,
		ST_MUL,
		ST_RD,
		ST_ADD,
		ST_READ,
		ST_READ2,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic scale;
		logic split;
		logic wrap;
		logic corner;
		logic mul;
		logic rd;
		logic add;
		logic read;
		logic read2;
		logic out_valid;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic last_corner;
		logic wrap_done;
		logic is_deposit;
		logic is_read;
	} sts_t;
endpackage

@@ hw/rtl/cgd_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module cgd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ hw/rtl/cgd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine sequencing clear, deposit and read requests.
module cgd_ctrl
	import cgd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_fire,
	input  logic   out_free,
	input  sts_t   sts,
	output logic   in_ready,
	output cmd_t   cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (sts.clr_done) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_fire) state_d = ST_SCALE;
			end
			ST_SCALE: begin
				if (sts.is_deposit) state_d = ST_SPLIT;
				else if (sts.is_read) state_d = ST_READ;
				else state_d = ST_OUT;
			end
			ST_SPLIT:  state_d = ST_WRAP;
			ST_WRAP:   if (sts.wrap_done) state_d = ST_CORNER;
			ST_CORNER: state_d = ST_MUL;
			ST_MUL:    state_d = ST_RD;
			ST_RD:     state_d = ST_ADD;
			ST_ADD:    state_d = sts.last_corner ? ST_OUT : ST_CORNER;
			ST_READ:   state_d = ST_READ2;
			ST_READ2:  state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR:  cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_fire;
			end
			ST_SCALE:  cmd.scale = 1'b1;
			ST_SPLIT:  cmd.split = 1'b1;
			ST_WRAP:   cmd.wrap = 1'b1;
			ST_CORNER: cmd.corner = 1'b1;
			ST_MUL:    cmd.mul = 1'b1;
			ST_RD:     cmd.rd = 1'b1;
			ST_ADD:    cmd.add = 1'b1;
			ST_READ:   cmd.read = 1'b1;
			ST_READ2:  cmd.read2 = 1'b1;
			ST_OUT:    cmd.out_valid = out_free;
			default:   cmd = '0;
		endcase
	end
endmodule

@@ hw/rtl/cgd_dp.sv @@
`timescale 1ns / 1ps
// Datapath: scaling, periodic wrap, weights, saturating grid accumulation.
module cgd_dp
	import cgd_pkg::*;
#(
	parameter int GRID_MAX  = GRID_MAX_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [1:0]       req_type,
	input  logic [31:0]      pos_x,
	input  logic [31:0]      pos_y,
	input  logic [31:0]      pos_z,
	input  logic [31:0]      particle_mass,
	input  logic [IDX_W-1:0] cell_index,
	input  logic             last_in_batch,
	input  logic [5:0]       grid_dims,
	input  logic [31:0]      scale_units,
	input  logic             fft_padding,
	input  logic [31:0]      const_mass,
	input  logic             use_item_mass,
	output logic [OUT_W-1:0] cell_value,
	output logic             saturated,
	output logic             batch_done
);
	localparam int DEPTH = GRID_MAX * GRID_MAX * (GRID_MAX + 2);
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(GRID_MAX + 1);
	localparam int SW    = $clog2(GRID_MAX + 3);
	localparam int PW    = 64 - 2 * FRAC_BITS;
	localparam int BW    = $clog2(PW);
	localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;
	localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	logic [1:0]  req_q;
	logic [31:0] pos_q [3];
	logic [31:0] mass_q;
	logic [IDX_W-1:0] cidx_q;
	logic        last_q;
	logic [CW-1:0] d_q;
	logic [SW-1:0] stride_q;
	logic [AW-1:0] plane_q;
	logic [63:0] prod_q [3];
	logic [PW-1:0] mag_q [3];
	logic          neg_q [3];
	logic [CW:0]   rem_q [3];
	logic [BW-1:0] bit_q;
	logic [FRAC_BITS-1:0] frac_q [3];
	logic [CW-1:0] lo_q [3];
	logic [CW-1:0] hi_q [3];
	logic [2:0]  corner_q;
	logic [AW-1:0] addr_q, clr_addr_q;
	logic [ACC_WIDTH-1:0] w_q;
	logic [2*FRAC_BITS+1:0] wxy_q;
	logic [FRAC_BITS:0] wxyz_q;
	logic        sat_q;
	logic        ram_we;
	logic [AW-1:0] ram_addr;
	logic [ACC_WIDTH-1:0] ram_wdata, ram_rdata;
	logic [CW-1:0] d_eff;

	always_comb begin
		d_eff = CW'({grid_dims[5:1], 1'b0});
		if ({grid_dims[5:1], 1'b0} < 6'd2) d_eff = CW'(2);
		if (32'({grid_dims[5:1], 1'b0}) > 32'(GRID_MAX)) d_eff = CW'(GRID_MAX);
	end

	// Periodic wrap: the magnitude of the floor is reduced modulo d one bit per cycle,
	// and a negative floor with a nonzero remainder maps to d minus that remainder.
	logic [CW:0]   rem_sh [3];
	logic [CW:0]   rem_next [3];
	logic [CW-1:0] lo_next [3];
	logic [CW-1:0] hi_next [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_sh[i] = {rem_q[i][CW-1:0], mag_q[i][PW-1]};
			rem_next[i] = (rem_sh[i] >= {1'b0, d_q}) ? rem_sh[i] - {1'b0, d_q} : rem_sh[i];
			lo_next[i] = (neg_q[i] && rem_next[i] != '0) ? d_q - rem_next[i][CW-1:0]
				: rem_next[i][CW-1:0];
			hi_next[i] = (lo_next[i] + CW'(1) == d_q) ? '0 : lo_next[i] + CW'(1);
		end
	end

	logic [FRAC_BITS:0] wsel [3];
	logic [CW-1:0]      csel [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wsel[i] = corner_q[i] ? {1'b0, frac_q[i]} : ONE_Q - {1'b0, frac_q[i]};
			csel[i] = corner_q[i] ? hi_q[i] : lo_q[i];
		end
	end

	logic [ACC_WIDTH:0] sum;
	assign sum = {1'b0, ram_rdata} + {1'b0, w_q};

	assign ram_we = cmd.clr_step || cmd.add || (cmd.read2 && req_q == REQ_RDCLR
		&& 32'(cidx_q) < 32'(DEPTH));
	assign ram_addr = cmd.clr_step ? clr_addr_q : (cmd.read ? AW'(cidx_q) : addr_q);
	assign ram_wdata = cmd.add ? (sum[ACC_WIDTH] ? ACC_MAX : sum[ACC_WIDTH-1:0]) : '0;

	cgd_ram #(.WIDTH(ACC_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step && 32'(clr_addr_q) != 32'(DEPTH - 1)) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	logic [2*FRAC_BITS+1:0] wxy_full;
	logic [3*FRAC_BITS+2:0] wxyz_full;
	logic [31+FRAC_BITS+1:0] mw_full;
	assign wxy_full  = (2*FRAC_BITS+2)'(wsel[0]) * (2*FRAC_BITS+2)'(wsel[1]);
	assign wxyz_full = (3*FRAC_BITS+3)'(wxy_q) * (3*FRAC_BITS+3)'(wsel[2]);
	assign mw_full   = (32+FRAC_BITS+1)'(mass_q) * (32+FRAC_BITS+1)'(wxyz_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			mass_q <= use_item_mass ? particle_mass : const_mass;
			cidx_q <= cell_index;
			last_q <= last_in_batch;
			d_q    <= d_eff;
			stride_q <= SW'(d_eff) + (fft_padding ? SW'(2) : SW'(0));
		end
		if (cmd.scale) begin
			for (int i = 0; i < 3; i++) begin
				prod_q[i] <= $signed(pos_q[i]) * $signed({1'b0, scale_units});
			end
			plane_q <= AW'(d_q) * AW'(stride_q);
			sat_q <= 1'b0;
			corner_q <= '0;
			cell_value <= '0;
			saturated <= 1'b0;
			batch_done <= 1'b0;
		end
		if (cmd.split) begin
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= prod_q[i][63];
				mag_q[i] <= prod_q[i][63] ? PW'(0) - prod_q[i][63:2*FRAC_BITS]
					: prod_q[i][63:2*FRAC_BITS];
				rem_q[i] <= '0;
				frac_q[i] <= prod_q[i][2*FRAC_BITS-1:FRAC_BITS];
			end
			bit_q <= '0;
		end
		if (cmd.wrap) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= mag_q[i] << 1;
				rem_q[i] <= rem_next[i];
				lo_q[i] <= lo_next[i];
				hi_q[i] <= hi_next[i];
			end
			bit_q <= bit_q + BW'(1);
		end
		if (cmd.corner) begin
			wxy_q  <= wxy_full >> FRAC_BITS;
			addr_q <= AW'(csel[0]) * plane_q + AW'(csel[1]) * AW'(stride_q) + AW'(csel[2]);
		end
		if (cmd.mul) begin
			wxyz_q <= (FRAC_BITS+1)'(wxyz_full >> FRAC_BITS);
		end
		if (cmd.rd) begin
			w_q <= ACC_WIDTH'(mw_full >> FRAC_BITS);
		end
		if (cmd.add) begin
			corner_q <= corner_q + 3'd1;
			if (sum[ACC_WIDTH]) sat_q <= 1'b1;
			saturated <= sat_q | sum[ACC_WIDTH];
			batch_done <= last_q;
		end
		if (cmd.read) begin
			addr_q <= AW'(cidx_q);
		end
		if (cmd.read2 && 32'(cidx_q) < 32'(DEPTH)) begin
			cell_value <= OUT_W'(ram_rdata);
		end
	end

	always_comb begin
		sts.clr_done   = 32'(clr_addr_q) == 32'(DEPTH - 1);
		sts.last_corner = corner_q == 3'd7;
		sts.wrap_done  = bit_q == BW'(PW - 1);
		sts.is_deposit = req_q == REQ_DEPOSIT;
		sts.is_read    = req_q == REQ_READ || req_q == REQ_RDCLR;
	end
endmodule

@@ hw/rtl/cic_grid_deposit.sv @@
`timescale 1ns / 1ps
// Top level of the cloud-in-cell grid deposition block.
// After reset the grid memory is cleared one cell per cycle, all
// GRID_MAX*GRID_MAX*(GRID_MAX+2) cells, before the first request is taken.
// A deposit request occupies the block for acceptance, scaling, the split, periodic
// wrap, then corner, multiply, read and add steps for each of the eight corners on the
// single memory port, and the result. Reads use two read steps in place of these, and
// unknown requests none. A result that is not taken holds the block.
module cic_grid_deposit
	import cgd_pkg::*;
#(
	parameter int GRID_MAX  = GRID_MAX_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, pos_z, particle_mass, cell_index[15:0]
	input  logic [143:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cell_value[47:0], saturated
	output logic [55:0]  m_tdata,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]  cfg_data
);
	cmd_t cmd;
	sts_t sts;
	logic [5:0]  dims_q;
	logic [31:0] scale_q, mass_q;
	logic        pad_q, item_q;
	logic        mv_q;
	logic [OUT_W-1:0] cv;
	logic sat, bd;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 6'd32;
			scale_q <= 32'd65536;
			pad_q <= 1'b0;
			mass_q <= 32'd65536;
			item_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID_DIMS: dims_q <= cfg_data[5:0];
				CFG_SCALE:     scale_q <= cfg_data;
				CFG_PADDING:   pad_q <= cfg_data[0];
				CFG_MASS:      mass_q <= cfg_data;
				CFG_ITEM_MASS: item_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (cmd.out_valid) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_valid) begin
			m_tdata <= {7'd0, sat, cv};
			m_tlast <= bd;
		end
	end
	assign m_tvalid = mv_q;

	cgd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.out_free(!mv_q || m_tready), .sts(sts), .in_ready(s_tready), .cmd(cmd)
	);

	cgd_dp #(.GRID_MAX(GRID_MAX), .FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(s_tuser), .pos_x(s_tdata[31:0]), .pos_y(s_tdata[63:32]),
		.pos_z(s_tdata[95:64]), .particle_mass(s_tdata[127:96]),
		.cell_index(s_tdata[143:128]), .last_in_batch(s_tlast),
		.grid_dims(dims_q), .scale_units(scale_q), .fft_padding(pad_q),
		.const_mass(mass_q), .use_item_mass(item_q),
		.cell_value(cv), .saturated(sat), .batch_done(bd)
	);
endmodule
